FILE: design/tbcd_pkg.sv
// shared types and constants for the two-button chord debouncer
package tbcd_pkg;

	// reset value of the debounce window in milliseconds
	localparam logic [15:0] DEBOUNCE_RESET = 16'd100;

	// one poll of the two buttons
	typedef struct packed {
		logic [31:0] now_ms;
		logic        first_down;
		logic        second_down;
	} poll_item_t;

	// events and debounced levels caused by one poll
	typedef struct packed {
		logic first_pressed;
		logic first_released;
		logic second_pressed;
		logic second_released;
		logic chord_pressed;
		logic chord_released;
		logic first_level;
		logic second_level;
		logic chord_level;
	} report_item_t;

	// true once more than the window has passed since the stamp, wrapping time
	function automatic logic settled(
		input logic [31:0] now,
		input logic [31:0] stamp,
		input logic [15:0] window
	);
		logic [31:0] elapsed;
		elapsed = now - stamp;
		return elapsed > {16'd0, window};
	endfunction

endpackage

FILE: design/tbcd_if.sv
// valid/ready channel interfaces for poll and report items
interface tbcd_poll_if;
	import tbcd_pkg::*;

	logic       valid;
	logic       ready;
	poll_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tbcd_report_if;
	import tbcd_pkg::*;

	logic         valid;
	logic         ready;
	report_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/two_button_chord_debouncer.sv
// Two-button debouncer with chord detection. Every poll item taken on the poll
// channel gives exactly one report item via the input and report registers. One
// poll item can be taken in every cycle unless the report side stalls: the whole
// debounce and chord update is one pass of three wrapping 32-bit subtract-and-
// compare paths between the input and report registers, and the debounce state
// is updated in that same cycle. The two registers act as a two-entry buffer, so
// a new item is taken while a report still waits. The debounce window resets to
// 100 ms. The user must write it through debounce_we/debounce_wdata only while
// the block is idle; the block itself does not enforce this.
module two_button_chord_debouncer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               debounce_we,
	input  logic [15:0]        debounce_wdata,
	tbcd_poll_if.sink          poll,
	tbcd_report_if.source      report
);
	import tbcd_pkg::*;

	logic [15:0]  debounce_q;
	logic         valid_s1;
	poll_item_t   item_s1;
	logic         advance;

	logic         primed_q;
	logic         first_last_q;
	logic         second_last_q;
	logic         chord_latch_q;
	logic         chord_last_q;
	logic [31:0]  first_stamp_q;
	logic [31:0]  second_stamp_q;
	logic [31:0]  chord_stamp_q;
	logic         skip_first_q;
	logic         skip_second_q;

	logic         out_valid_q;
	report_item_t out_q;

	logic         first_ref;
	logic         second_ref;
	logic         first_chg;
	logic         second_chg;
	logic         latch_next;
	logic         chord_chg;
	logic         skip_first_next;
	logic         skip_second_next;
	report_item_t res;

	// handshake: input stage moves on when the report register is free
	assign advance    = valid_s1 && (!out_valid_q || report.ready);
	assign poll.ready = !valid_s1 || advance;
	assign report.valid = out_valid_q;
	assign report.data  = out_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (debounce_we) begin
			debounce_q <= debounce_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			item_s1 <= poll.data;
		end
	end

	// debounce and chord logic for the item in the input register
	always_comb begin
		// first item only captures the levels
		first_ref  = primed_q ? first_last_q : item_s1.first_down;
		second_ref = primed_q ? second_last_q : item_s1.second_down;

		first_chg  = (first_ref != item_s1.first_down) &&
			settled(item_s1.now_ms, first_stamp_q, debounce_q);
		second_chg = (second_ref != item_s1.second_down) &&
			settled(item_s1.now_ms, second_stamp_q, debounce_q);

		// latch sets on both down, clears on both up
		if (chord_latch_q) begin
			latch_next = item_s1.first_down || item_s1.second_down;
		end else begin
			latch_next = item_s1.first_down && item_s1.second_down;
		end
		chord_chg = (chord_last_q != latch_next) &&
			settled(item_s1.now_ms, chord_stamp_q, debounce_q);

		// a release consumes its skip flag, a chord press arms both
		skip_first_next  = (first_chg && !item_s1.first_down) ? 1'b0 : skip_first_q;
		skip_second_next = (second_chg && !item_s1.second_down) ? 1'b0 : skip_second_q;
		if (chord_chg && latch_next) begin
			skip_first_next  = 1'b1;
			skip_second_next = 1'b1;
		end

		res.first_pressed   = first_chg && item_s1.first_down;
		res.first_released  = first_chg && !item_s1.first_down && !skip_first_q;
		res.second_pressed  = second_chg && item_s1.second_down;
		res.second_released = second_chg && !item_s1.second_down && !skip_second_q;
		res.chord_pressed   = chord_chg && latch_next;
		res.chord_released  = chord_chg && !latch_next;
		res.first_level     = first_chg ? item_s1.first_down : first_ref;
		res.second_level    = second_chg ? item_s1.second_down : second_ref;
		res.chord_level     = chord_chg ? latch_next : chord_last_q;
	end

	// debounce state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q       <= 1'b0;
			first_last_q   <= 1'b0;
			second_last_q  <= 1'b0;
			chord_latch_q  <= 1'b0;
			chord_last_q   <= 1'b0;
			first_stamp_q  <= '0;
			second_stamp_q <= '0;
			chord_stamp_q  <= '0;
			skip_first_q   <= 1'b0;
			skip_second_q  <= 1'b0;
		end else if (advance) begin
			primed_q      <= 1'b1;
			first_last_q  <= res.first_level;
			second_last_q <= res.second_level;
			chord_latch_q <= latch_next;
			chord_last_q  <= res.chord_level;
			skip_first_q  <= skip_first_next;
			skip_second_q <= skip_second_next;
			if (first_chg) begin
				first_stamp_q <= item_s1.now_ms;
			end
			if (second_chg) begin
				second_stamp_q <= item_s1.now_ms;
			end
			if (chord_chg) begin
				chord_stamp_q <= item_s1.now_ms;
			end
		end
	end

	// report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	// stamps only move when an item is processed
	a_stamp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(first_stamp_q) && $stable(second_stamp_q) &&
		$stable(chord_stamp_q))
		else $error("debounce stamp changed without an item");

	// a full buffer with a stalled report must refuse new items
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !report.ready) |-> !poll.ready)
		else $error("poll item taken while both stages are full");

	// once primed, stays primed until reset
	a_primed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		primed_q |=> primed_q)
		else $error("primed flag cleared");

	// a reported chord press leaves the chord level high
	a_chord_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.chord_pressed) |-> out_q.chord_level)
		else $error("chord press reported with chord level low");

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the two-button chord debouncer
module tb_top;
	import tbcd_pkg::*;

	typedef enum logic {ROW_POLL, ROW_WINDOW} row_kind_t;
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// one row of the directed table: a poll item or a window write
	typedef struct {
		row_kind_t    kind;
		logic [31:0]  value;
		logic         first_down;
		logic         second_down;
		bit           typed;
		report_item_t report;
	} stim_row_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_COUNT = 8;
	localparam int PHASE_ITEMS = 166;
	localparam int TAIL_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        debounce_we;
	logic [15:0] debounce_wdata;

	tbcd_poll_if   poll_ch ();
	tbcd_report_if report_ch ();

	two_button_chord_debouncer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.debounce_we   (debounce_we),
		.debounce_wdata(debounce_wdata),
		.poll          (poll_ch),
		.report        (report_ch)
	);

	// report bit order: first_pressed at the top, chord_level at the bottom
	string field_names [9] = '{"chord_level", "second_level", "first_level",
		"chord_released", "chord_pressed", "second_released", "second_pressed",
		"first_released", "first_pressed"};

	// directed table: reset value of the window first, then zero, then the maximum
	stim_row_t directed_rows [19] = '{
		'{ROW_POLL,   32'h0000_0000, 1'b1, 1'b1, 1'b1, 9'b000000_110},
		'{ROW_POLL,   32'h0000_0064, 1'b0, 1'b0, 1'b1, 9'b000000_110},
		'{ROW_POLL,   32'h0000_0065, 1'b0, 1'b0, 1'b1, 9'b010100_000},
		'{ROW_POLL,   32'h0000_012C, 1'b1, 1'b1, 1'b1, 9'b101010_111},
		'{ROW_POLL,   32'h0000_01F4, 1'b0, 1'b0, 1'b1, 9'b000001_000},
		'{ROW_POLL,   32'h0000_0258, 1'b1, 1'b0, 1'b0, 9'b0},
		'{ROW_POLL,   32'h0000_0259, 1'b1, 1'b0, 1'b0, 9'b0},
		'{ROW_POLL,   32'hFFFF_FFF0, 1'b0, 1'b1, 1'b0, 9'b0},
		'{ROW_POLL,   32'h0000_0050, 1'b1, 1'b1, 1'b0, 9'b0},
		'{ROW_POLL,   32'h0000_0060, 1'b1, 1'b1, 1'b0, 9'b0},
		'{ROW_WINDOW, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 9'b0},
		'{ROW_POLL,   32'h0000_0060, 1'b0, 1'b0, 1'b0, 9'b0},
		'{ROW_POLL,   32'h0000_0061, 1'b0, 1'b0, 1'b0, 9'b0},
		'{ROW_POLL,   32'h0000_0061, 1'b1, 1'b1, 1'b0, 9'b0},
		'{ROW_WINDOW, 32'h0000_FFFF, 1'b0, 1'b0, 1'b0, 9'b0},
		'{ROW_POLL,   32'h0001_0060, 1'b0, 1'b0, 1'b0, 9'b0},
		'{ROW_POLL,   32'h0001_0062, 1'b0, 1'b0, 1'b0, 9'b0},
		'{ROW_POLL,   32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 9'b0},
		'{ROW_POLL,   32'h0000_0000, 1'b0, 1'b1, 1'b0, 9'b0}
	};

	// window of each random phase; phases 3 and 7 draw their own
	logic [15:0] phase_windows [PHASE_COUNT] = '{16'd0, 16'd1, 16'hFFFF, 16'd0,
		16'hFFFF, 16'd100, 16'd0, 16'd0};

	// debouncer state as predicted from the poll items taken so far
	logic [15:0] window_ms = DEBOUNCE_RESET;
	logic        primed = 1'b0;
	logic        btn_level [2] = '{1'b0, 1'b0};
	logic [31:0] btn_stamp [2] = '{32'd0, 32'd0};
	logic        btn_skip [2] = '{1'b0, 1'b0};
	logic        chord_latch = 1'b0;
	logic        chord_level = 1'b0;
	logic [31:0] chord_stamp = 32'd0;

	report_item_t pending_reports [$];
	int           mismatches = 0;
	int           cycles = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;

	always #10 clk = ~clk;

	// more than the window since the stamp, with wrapping time
	function automatic bit window_passed(input logic [31:0] now, input logic [31:0] stamp);
		logic [31:0] elapsed;
		elapsed = now - stamp;
		return elapsed > {16'd0, window_ms};
	endfunction

	// events and levels for one poll item, advancing the predicted state
	function automatic report_item_t predict_report(input poll_item_t p);
		report_item_t r;
		logic         down [2];
		logic         pressed [2];
		logic         released [2];
		down[0] = p.first_down;
		down[1] = p.second_down;
		// the first poll only captures the levels
		if (!primed) begin
			primed = 1'b1;
			btn_level[0] = down[0];
			btn_level[1] = down[1];
		end
		// first button, then second
		for (int i = 0; i < 2; i++) begin
			pressed[i] = 1'b0;
			released[i] = 1'b0;
			if (btn_level[i] != down[i] && window_passed(p.now_ms, btn_stamp[i])) begin
				btn_level[i] = down[i];
				btn_stamp[i] = p.now_ms;
				if (down[i]) begin
					pressed[i] = 1'b1;
				end else begin
					released[i] = !btn_skip[i];
					btn_skip[i] = 1'b0;
				end
			end
		end
		// latch sets on both down and clears on both up
		if (chord_latch)
			chord_latch = down[0] | down[1];
		else
			chord_latch = down[0] & down[1];
		r = '0;
		// debounced chord, a press hides the next release of each button
		if (chord_level != chord_latch && window_passed(p.now_ms, chord_stamp)) begin
			chord_level = chord_latch;
			chord_stamp = p.now_ms;
			if (chord_latch) begin
				r.chord_pressed = 1'b1;
				btn_skip[0] = 1'b1;
				btn_skip[1] = 1'b1;
			end else begin
				r.chord_released = 1'b1;
			end
		end
		r.first_pressed = pressed[0];
		r.first_released = released[0];
		r.second_pressed = pressed[1];
		r.second_released = released[1];
		r.first_level = btn_level[0];
		r.second_level = btn_level[1];
		r.chord_level = chord_level;
		return r;
	endfunction

	// offer one poll item, with random idle cycles ahead of it
	task automatic send_poll(input poll_item_t item, input bit typed,
			input report_item_t typed_report);
		report_item_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			poll_ch.valid <= 1'b0;
			@(posedge clk);
		end
		poll_ch.valid <= 1'b1;
		poll_ch.data <= item;
		do @(posedge clk); while (!poll_ch.ready);
		predicted = predict_report(item);
		pending_reports.push_back(typed ? typed_report : predicted);
	endtask

	// window write once every report is back
	task automatic write_window(input logic [15:0] value);
		poll_ch.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		debounce_we <= 1'b1;
		debounce_wdata <= value;
		@(posedge clk);
		debounce_we <= 1'b0;
		window_ms = value;
	endtask

	// report side stalls at random
	always @(posedge clk) begin
		report_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// compare each report item with the oldest prediction
	always @(posedge clk) begin
		logic [8:0] want;
		logic [8:0] got;
		if (arst_n && report_ch.valid && report_ch.ready) begin
			got = report_ch.data;
			if (pending_reports.size() == 0) begin
				mismatches++;
				$display("%0t: report item with nothing pending, expected none, actual %b",
					$time, got);
			end else begin
				want = pending_reports.pop_front();
				for (int i = 0; i < 9; i++) begin
					if (want[i] !== got[i]) begin
						mismatches++;
						$display("%0t: %s expected %b, actual %b", $time,
							field_names[i], want[i], got[i]);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// stimulus
	initial begin
		poll_item_t  item;
		logic [31:0] wall_ms;
		logic        hold_first;
		logic        hold_second;
		logic [15:0] window_next;
		int          pick;

		arst_n = 1'b0;
		debounce_we = 1'b0;
		debounce_wdata = 16'd0;
		poll_ch.valid = 1'b0;
		poll_ch.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (directed_rows[k]) begin
			if (directed_rows[k].kind == ROW_WINDOW) begin
				write_window(directed_rows[k].value[15:0]);
			end else begin
				item.now_ms = directed_rows[k].value;
				item.first_down = directed_rows[k].first_down;
				item.second_down = directed_rows[k].second_down;
				send_poll(item, directed_rows[k].typed, directed_rows[k].report);
			end
		end

		// random phases: button sequences with bounce, time steps around the window
		wall_ms = 32'd0;
		hold_first = 1'b0;
		hold_second = 1'b0;
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			if (ph == 3)
				window_next = 16'($urandom_range(1000, 2));
			else if (ph == 7)
				window_next = 16'($urandom);
			else
				window_next = phase_windows[ph];
			write_window(window_next);
			case (idle_mode_t'(ph % 4))
				IDLE_NONE: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				IDLE_SENDER: begin
					send_idle_pct = 46;
					recv_stall_pct = 0;
				end
				IDLE_RECEIVER: begin
					send_idle_pct = 0;
					recv_stall_pct = 46;
				end
				default: begin
					send_idle_pct = 34;
					recv_stall_pct = 34;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// time step: jump, window edge, bounce-sized or settle-sized
				pick = $urandom_range(99);
				if (pick < 6)
					wall_ms = $urandom;
				else if (pick < 20)
					wall_ms += window_ms + 32'($urandom_range(1));
				else if (pick < 70)
					wall_ms += $urandom_range(window_ms / 4 + 2);
				else
					wall_ms += $urandom_range(2 * window_ms + 2, window_ms / 2);
				// held levels: chord moves, single presses and releases
				pick = $urandom_range(99);
				if (pick < 10) begin
					hold_first = 1'($urandom_range(1));
					hold_second = hold_first;
				end else if (pick < 20) begin
					hold_first = !hold_first;
				end else if (pick < 30) begin
					hold_second = !hold_second;
				end
				item.now_ms = wall_ms;
				if ($urandom_range(99) < 15) begin
					item.first_down = 1'($urandom_range(1));
					item.second_down = 1'($urandom_range(1));
				end else begin
					item.first_down = hold_first;
					item.second_down = hold_second;
				end
				send_poll(item, 1'b0, '0);
			end
		end

		// drain
		poll_ch.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
